/* design/nth_prime_table_engine_defines.svh */
// Assertion macros for the nth prime table engine.
// Used by the top level; needs clk and rst_n in scope.
`ifndef NTH_PRIME_TABLE_ENGINE_DEFINES_SVH
`define NTH_PRIME_TABLE_ENGINE_DEFINES_SVH
`define NPTE_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("npte check failed");
`define NPTE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("npte check failed");
`endif

/* design/npte_pkg.sv */
// Shared types and constants for the nth prime table engine.
// No dependencies.
`default_nettype none
package npte_pkg;
  localparam int NPTE_MAX_PRIMES = 65536;
  localparam int IDX_W = 18;
  localparam int VAL_W = 21;
  localparam int SEED_N = 4;
  localparam logic [VAL_W-1:0] VAL_MAX = {VAL_W{1'b1}};

  typedef enum logic [3:0] {
    ST_IDLE, ST_LOOK_RD, ST_LOOK_WT, ST_NEXT, ST_FETCH, ST_WAIT,
    ST_SQ, ST_CMP, ST_DIV, ST_ADD, ST_RESP
  } npte_state_t;

  typedef struct packed {
    logic load_req;
    logic cand_ld;
    logic cand_inc;
    logic k_clr;
    logic k_inc;
    logic rd_issue;
    logic rd_sel_k;
    logic p_load;
    logic sq_load;
    logic div_start;
    logic div_step;
    logic write_prime;
    logic res_err;
    logic res_rd;
    logic res_cand;
    logic out_load;
  } npte_cmd_t;

  typedef struct packed {
    logic req_bad;
    logic req_hit;
    logic cand_max;
    logic k_end;
    logic sq_gt;
    logic div_done;
    logic rem_zero;
    logic pos_reached;
    logic out_busy;
  } npte_stat_t;

  function automatic logic [VAL_W-1:0] npte_seed(input logic [1:0] i);
    logic [VAL_W-1:0] v;
    unique case (i)
      2'd0: v = VAL_W'(2);
      2'd1: v = VAL_W'(3);
      2'd2: v = VAL_W'(5);
      default: v = VAL_W'(7);
    endcase
    return v;
  endfunction
endpackage
`default_nettype wire

/* design/nth_prime_table_engine.sv */
// Nth prime table engine: request in, prime at that one-based position out.
// A request whose position is already stored passes through accept, table
// read, registered read and result load.
// A request past the table walks candidates; each divisor test runs fetch,
// square, compare and a bit-serial remainder, so the latency is set by that
// remainder unit and by how many primes are appended.
// Position zero or above MAX_PRIMES answers status 1, value 0.
// One request is in work at a time; in_ready is high while idle, even while a
// finished result still waits in the output register.
// out_valid holds with its fields until the transfer; a stalled receiver holds
// the engine in its response state. Reset restores the seed primes 2, 3, 5, 7
// (served from constants) and empties the rest; no clearing pass is needed.
// Depends on npte_pkg, npte_ctrl, npte_dp and the defines header.
`default_nettype none
`include "nth_prime_table_engine_defines.svh"
module nth_prime_table_engine
  import npte_pkg::*;
#(
  parameter int MAX_PRIMES = NPTE_MAX_PRIMES
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [IDX_W-1:0] in_request_index,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic      [VAL_W-1:0] out_prime_value,
  output logic                  out_status
);
  npte_cmd_t  cmd;
  npte_stat_t stat;

  npte_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .stat    (stat),
    .cmd     (cmd)
  );

  npte_dp #(.MAX_PRIMES(MAX_PRIMES)) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_request_index(in_request_index),
    .cmd             (cmd),
    .stat            (stat),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_prime_value (out_prime_value),
    .out_status      (out_status)
  );

  `NPTE_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
  `NPTE_ASSERT_SAME(a_err_zero, out_valid && out_status, out_prime_value == '0)
  `NPTE_ASSERT_SAME(a_ok_prime, out_valid && !out_status, out_prime_value >= VAL_W'(2))
  `NPTE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_prime_value))
endmodule
`default_nettype wire

/* design/npte_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`default_nettype none
module npte_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

/* design/npte_ctrl.sv */
// Controller state machine for the nth prime table engine.
// Depends on npte_pkg.
`default_nettype none
module npte_ctrl
  import npte_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire npte_stat_t stat,
  output npte_cmd_t       cmd
);
  npte_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_req = 1'b1;
          if (stat.req_bad) begin
            cmd.res_err = 1'b1;
            state_nxt = ST_RESP;
          end else if (stat.req_hit) begin
            state_nxt = ST_LOOK_RD;
          end else begin
            cmd.cand_ld = 1'b1;
            state_nxt = ST_NEXT;
          end
        end
      end
      ST_LOOK_RD: begin
        cmd.rd_issue = 1'b1;
        state_nxt = ST_LOOK_WT;
      end
      ST_LOOK_WT: begin
        cmd.res_rd = 1'b1;
        state_nxt = ST_RESP;
      end
      ST_NEXT: begin
        if (stat.cand_max) begin
          cmd.res_err = 1'b1;
          state_nxt = ST_RESP;
        end else begin
          cmd.cand_inc = 1'b1;
          cmd.k_clr = 1'b1;
          state_nxt = ST_FETCH;
        end
      end
      ST_FETCH: begin
        if (stat.k_end) begin
          state_nxt = ST_ADD;
        end else begin
          cmd.rd_issue = 1'b1;
          cmd.rd_sel_k = 1'b1;
          state_nxt = ST_WAIT;
        end
      end
      ST_WAIT: begin
        cmd.p_load = 1'b1;
        state_nxt = ST_SQ;
      end
      ST_SQ: begin
        cmd.sq_load = 1'b1;
        state_nxt = ST_CMP;
      end
      ST_CMP: begin
        if (stat.sq_gt) begin
          state_nxt = ST_ADD;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (!stat.div_done) begin
          cmd.div_step = 1'b1;
        end else if (stat.rem_zero) begin
          state_nxt = ST_NEXT;
        end else begin
          cmd.k_inc = 1'b1;
          state_nxt = ST_FETCH;
        end
      end
      ST_ADD: begin
        cmd.write_prime = 1'b1;
        if (stat.pos_reached) begin
          cmd.res_cand = 1'b1;
          state_nxt = ST_RESP;
        end else begin
          state_nxt = ST_NEXT;
        end
      end
      ST_RESP: begin
        if (!stat.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

/* design/npte_dp.sv */
// Datapath: prime table, candidate, divisor walk, serial remainder, result.
// Depends on npte_pkg and npte_ram.
`default_nettype none
module npte_dp
  import npte_pkg::*;
#(
  parameter int MAX_PRIMES = NPTE_MAX_PRIMES
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic [IDX_W-1:0] in_request_index,
  input  wire npte_cmd_t        cmd,
  output npte_stat_t            stat,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic      [VAL_W-1:0] out_prime_value,
  output logic                  out_status
);
  localparam int AW = $clog2(MAX_PRIMES);
  localparam int CW = $clog2(MAX_PRIMES + 1);
  localparam int DCW = $clog2(VAL_W + 1);

  logic [IDX_W-1:0]   pos_r;
  logic [CW-1:0]      count_r, k_r;
  logic [VAL_W-1:0]   last_r, cand_r, p_r, rem_r, dvd_r, res_val_r;
  logic [2*VAL_W-1:0] sq_r;
  logic [DCW-1:0]     dcnt_r;
  logic               res_err_r, const_sel_r, out_valid_r;
  logic [1:0]         idx_lo_r;
  logic [VAL_W-1:0]   ram_rdata, rd_val;
  logic [CW-1:0]      rd_idx;
  logic [VAL_W:0]     rem_sh, rem_sub;

  assign rd_idx = cmd.rd_sel_k ? k_r : CW'(32'(pos_r) - 32'd1);
  assign rd_val = const_sel_r ? npte_seed(idx_lo_r) : ram_rdata;

  npte_ram #(.WIDTH(VAL_W), .DEPTH(MAX_PRIMES)) u_table (
    .clk  (clk),
    .we   (cmd.write_prime),
    .waddr(count_r[AW-1:0]),
    .wdata(cand_r),
    .re   (cmd.rd_issue),
    .raddr(rd_idx[AW-1:0]),
    .rdata(ram_rdata)
  );

  assign rem_sh  = {rem_r, dvd_r[VAL_W-1]};
  assign rem_sub = rem_sh - {1'b0, p_r};

  always_comb begin
    stat.req_bad     = (in_request_index == '0) ||
                       (32'(in_request_index) > 32'(MAX_PRIMES));
    stat.req_hit     = 32'(in_request_index) <= 32'(count_r);
    stat.cand_max    = cand_r == VAL_MAX;
    stat.k_end       = k_r == count_r;
    stat.sq_gt       = sq_r > (2*VAL_W)'(cand_r);
    stat.div_done    = dcnt_r == '0;
    stat.rem_zero    = rem_r == '0;
    stat.pos_reached = (32'(count_r) + 32'd1) == 32'(pos_r);
    stat.out_busy    = out_valid_r && !out_ready;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= CW'(SEED_N);
      last_r      <= VAL_W'(7);
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.write_prime) begin
        count_r <= count_r + 1'b1;
        last_r  <= cand_r;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      pos_r <= in_request_index;
    end
    if (cmd.cand_ld) begin
      cand_r <= last_r;
    end else if (cmd.cand_inc) begin
      cand_r <= cand_r + 1'b1;
    end
    if (cmd.k_clr) begin
      k_r <= '0;
    end else if (cmd.k_inc) begin
      k_r <= k_r + 1'b1;
    end
    if (cmd.rd_issue) begin
      const_sel_r <= 32'(rd_idx) < SEED_N;
      idx_lo_r    <= rd_idx[1:0];
    end
    if (cmd.p_load) begin
      p_r <= rd_val;
    end
    if (cmd.sq_load) begin
      sq_r <= p_r * p_r;
    end
    if (cmd.div_start) begin
      rem_r  <= '0;
      dvd_r  <= cand_r;
      dcnt_r <= DCW'(VAL_W);
    end else if (cmd.div_step) begin
      rem_r  <= rem_sub[VAL_W] ? rem_sh[VAL_W-1:0] : rem_sub[VAL_W-1:0];
      dvd_r  <= {dvd_r[VAL_W-2:0], 1'b0};
      dcnt_r <= dcnt_r - 1'b1;
    end
    if (cmd.res_err) begin
      res_val_r <= '0;
      res_err_r <= 1'b1;
    end else if (cmd.res_rd) begin
      res_val_r <= rd_val;
      res_err_r <= 1'b0;
    end else if (cmd.res_cand) begin
      res_val_r <= cand_r;
      res_err_r <= 1'b0;
    end
    if (cmd.out_load) begin
      out_prime_value <= res_val_r;
      out_status      <= res_err_r;
    end
  end

  assign out_valid = out_valid_r;
endmodule
`default_nettype wire
